>>> rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types, sizes and command codes for the all-pairs shortest-path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

	localparam int MAX_NODES = 64;
	localparam int DIST_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int NC_W      = $clog2(MAX_NODES + 1);
	localparam int CFG_W     = 7;
	localparam int CNT_W     = (NC_W > CFG_W) ? NC_W : CFG_W;

	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] duration;
	} cmd_beat_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic        done_res;
	} res_beat_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		dist_t wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic      valid;
		res_beat_t beat;
	} res_push_t;

	function automatic logic in_range(input logic [5:0] r, input logic [5:0] c);
		return (int'(r) < MAX_NODES) && (int'(c) < MAX_NODES);
	endfunction

	function automatic addr_t cell_addr(input idx_t r, input idx_t c);
		return {r, c};
	endfunction

endpackage

>>> rtl/apsp_mem.sv
// ----------------------------------------------------------------------------
// apsp_mem
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module apsp_mem (
	input  logic              clk,
	input  apsp_pkg::mem_req_t req,
	output apsp_pkg::dist_t   rd_a,
	output apsp_pkg::dist_t   rd_b
);

	apsp_pkg::dist_t mem_q [apsp_pkg::MEM_DEPTH];
	apsp_pkg::dist_t rd_a_q;
	apsp_pkg::dist_t rd_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_a_q <= mem_q[req.raddr_a];
		rd_b_q <= mem_q[req.raddr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

>>> rtl/apsp_relax.sv
// ----------------------------------------------------------------------------
// apsp_relax
// Add and compare unit: path through the intermediate node versus
// the current entry.
// ----------------------------------------------------------------------------
module apsp_relax (
	input  apsp_pkg::dist_t left,
	input  apsp_pkg::dist_t via_val,
	input  apsp_pkg::dist_t cur,
	output apsp_pkg::dist_t sum,
	output logic            shorter
);

	logic [apsp_pkg::DIST_BITS:0] wide_sum;

	assign wide_sum = {1'b0, left} + {1'b0, via_val};
	assign shorter  = wide_sum < {1'b0, cur};
	assign sum      = wide_sum[apsp_pkg::DIST_BITS-1:0];

endmodule

>>> rtl/apsp_seq.sv
// ----------------------------------------------------------------------------
// apsp_seq
// Command sequencer: entry writes and reads, and the closure sweep with the
// intermediate node outermost; an entry update spans states S_RD and S_UPD.
// ----------------------------------------------------------------------------
module apsp_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  apsp_pkg::cmd_beat_t             cmd_beat,
	input  logic [apsp_pkg::CFG_W-1:0]      node_count,
	input  logic                            res_ready,
	output apsp_pkg::res_push_t             push,
	output apsp_pkg::mem_req_t              mem_req,
	input  apsp_pkg::dist_t                 rd_a,
	input  apsp_pkg::dist_t                 rd_b
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROW   = 3'd1;
	localparam logic [2:0] S_LEFT  = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_RDOUT = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]      state_q;
	apsp_pkg::idx_t  via_q;
	apsp_pkg::idx_t  from_q;
	apsp_pkg::idx_t  to_q;
	apsp_pkg::dist_t left_q;
	apsp_pkg::addr_t rd_addr_q;
	logic            rd_ok_q;

	apsp_pkg::cnt_t  node_ext;
	apsp_pkg::cnt_t  n_eff;
	logic            t_last;
	logic            f_last;
	logic            v_last;
	logic            accept;
	logic            beat_ok;
	apsp_pkg::addr_t beat_addr;
	apsp_pkg::dist_t sum;
	logic            shorter;

	assign node_ext = apsp_pkg::cnt_t'(node_count);
	assign n_eff    = (node_ext > apsp_pkg::cnt_t'(apsp_pkg::MAX_NODES)) ?
		apsp_pkg::cnt_t'(apsp_pkg::MAX_NODES) : node_ext;
	assign t_last   = (apsp_pkg::cnt_t'(to_q) + apsp_pkg::cnt_t'(1)) == n_eff;
	assign f_last   = (apsp_pkg::cnt_t'(from_q) + apsp_pkg::cnt_t'(1)) == n_eff;
	assign v_last   = (apsp_pkg::cnt_t'(via_q) + apsp_pkg::cnt_t'(1)) == n_eff;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign beat_ok   = apsp_pkg::in_range(cmd_beat.row, cmd_beat.col);
	assign beat_addr = apsp_pkg::cell_addr(apsp_pkg::idx_t'(cmd_beat.row),
		apsp_pkg::idx_t'(cmd_beat.col));

	apsp_relax u_relax (
		.left    (left_q),
		.via_val (rd_a),
		.cur     (rd_b),
		.sum     (sum),
		.shorter (shorter)
	);

	always_comb begin
		mem_req         = '0;
		mem_req.raddr_a = rd_addr_q;
		mem_req.raddr_b = apsp_pkg::cell_addr(from_q, to_q);
		push            = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.raddr_a = beat_addr;
				mem_req.waddr   = beat_addr;
				mem_req.wdata   = apsp_pkg::dist_t'(cmd_beat.duration);
				mem_req.we      = accept && (cmd_beat.cmd == apsp_pkg::CMD_WRITE) && beat_ok;
			end
			S_ROW: begin
				mem_req.raddr_a = apsp_pkg::cell_addr(from_q, via_q);
			end
			S_LEFT: begin
				mem_req.raddr_a = apsp_pkg::cell_addr(from_q, via_q);
			end
			S_RD: begin
				mem_req.raddr_a = apsp_pkg::cell_addr(via_q, to_q);
			end
			S_UPD: begin
				mem_req.raddr_a = apsp_pkg::cell_addr(via_q, to_q);
				mem_req.waddr   = apsp_pkg::cell_addr(from_q, to_q);
				mem_req.wdata   = sum;
				mem_req.we      = shorter;
			end
			S_RDOUT: begin
				push.valid           = 1'b1;
				push.beat.read_value = rd_ok_q ? 16'(rd_a) : 16'd0;
				push.beat.done_res   = 1'b0;
			end
			S_DONE: begin
				push.valid           = 1'b1;
				push.beat.read_value = 16'd0;
				push.beat.done_res   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LEFT) begin
			left_q <= rd_a;
		end
		if (accept) begin
			rd_addr_q <= beat_addr;
			rd_ok_q   <= beat_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			via_q   <= '0;
			from_q  <= '0;
			to_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_beat.cmd)
							apsp_pkg::CMD_RUN: begin
								via_q  <= '0;
								from_q <= '0;
								to_q   <= '0;
								state_q <= (n_eff == '0) ? S_DONE : S_ROW;
							end
							apsp_pkg::CMD_READ: state_q <= S_RDOUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ROW:  state_q <= S_LEFT;
				S_LEFT: state_q <= S_RD;
				S_RD:   state_q <= S_UPD;
				S_UPD: begin
					if (!t_last) begin
						to_q    <= to_q + 1'b1;
						state_q <= S_RD;
					end else begin
						to_q <= '0;
						if (!f_last) begin
							from_q  <= from_q + 1'b1;
							state_q <= S_ROW;
						end else begin
							from_q <= '0;
							if (!v_last) begin
								via_q   <= via_q + 1'b1;
								state_q <= S_ROW;
							end else begin
								via_q   <= '0;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_RDOUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/all_pairs_shortest_path_closure.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_closure
// Distance matrix with entry write and read, and an in-place shortest-path
// closure over the first node_count nodes, at most MAX_NODES.
//
//   channel   dir   beat          handshake
//   cmd       in    cmd_beat_t    cmd_valid / cmd_stall
//   res       out   res_beat_t    res_valid / res_stall
//   cfg       in    node_count    cfg_we / cfg_wdata
//
// read: the entry passes the store's read register, then the output register.
// closure: every entry update is a read of two entries, one add and compare,
// and a write when the sum is shorter, all through one memory.
// cmd_stall is high from the accepted read or closure beat until its result
// enters the output register; a stalled result register holds the block.
// reset clears control only; the distance store holds nothing until written.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_closure (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  apsp_pkg::cmd_beat_t         cmd_beat,
	output logic                        res_valid,
	input  logic                        res_stall,
	output apsp_pkg::res_beat_t         res_beat,
	input  logic                        cfg_we,
	input  logic [apsp_pkg::CFG_W-1:0]  cfg_wdata
);

	logic [apsp_pkg::CFG_W-1:0] node_count_q;
	logic                       res_valid_q;
	apsp_pkg::res_beat_t        res_beat_q;
	logic                       res_ready;
	apsp_pkg::res_push_t        push;
	apsp_pkg::mem_req_t         mem_req;
	apsp_pkg::dist_t            rd_a;
	apsp_pkg::dist_t            rd_b;

	assign res_ready = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= apsp_pkg::NODE_COUNT_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (res_ready) begin
				res_valid_q <= push.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && push.valid) begin
			res_beat_q <= push.beat;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_beat_q;

	apsp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_beat   (cmd_beat),
		.node_count (node_count_q),
		.res_ready  (res_ready),
		.push       (push),
		.mem_req    (mem_req),
		.rd_a       (rd_a),
		.rd_b       (rd_b)
	);

	apsp_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

endmodule

>>> rtl/apsp_chk.sv
// ----------------------------------------------------------------------------
// apsp_chk
// Port-level checks for the shortest-path closure block, bound to the top.
// ----------------------------------------------------------------------------
module apsp_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_stall,
	input apsp_pkg::cmd_beat_t        cmd_beat,
	input logic                       res_valid,
	input logic                       res_stall,
	input apsp_pkg::res_beat_t        res_beat
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_beat))
		else $error("result beat dropped or changed while stalled");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.done_res |-> res_beat.read_value == 16'd0)
		else $error("done beat carries a value");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_beat.cmd == apsp_pkg::CMD_RUN |=> cmd_stall)
		else $error("closure run accepted without going busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd_beat.cmd == apsp_pkg::CMD_READ |=> cmd_stall)
		else $error("read accepted without going busy");

endmodule

bind all_pairs_shortest_path_closure apsp_chk u_apsp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_beat  (cmd_beat),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_beat  (res_beat)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for all_pairs_shortest_path_closure. A clocked driver
// sends command beats from a queue that the stimulus block fills: a short
// directed set, then closure runs over small random graphs mixed with stray
// writes, reads and unused commands, and an oversized node count at the end.
// A shadow distance matrix predicts every reply. The monitor compares each
// reply field by field under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 800;
	localparam int         SETTLE       = 4;
	localparam int         TAIL_CYCLES  = 20;
	localparam int         CYCLE_LIMIT  = 3000000;

	typedef enum logic [1:0] {ACT_BEAT, ACT_CFG, ACT_DRAIN} act_kind_t;
	typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} pace_t;

	typedef struct {
		act_kind_t                  kind;
		pace_t                      mode;
		apsp_pkg::cmd_beat_t        beat;
		logic [apsp_pkg::CFG_W-1:0] nodes;
	} drive_act_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cmd_valid = 1'b0;
	logic                       cmd_stall;
	apsp_pkg::cmd_beat_t        cmd_beat  = '0;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	apsp_pkg::res_beat_t        res_beat;
	logic                       cfg_we    = 1'b0;
	logic [apsp_pkg::CFG_W-1:0] cfg_wdata = '0;

	// shadow of the block
	apsp_pkg::dist_t            route_minutes [apsp_pkg::MEM_DEPTH];
	logic [apsp_pkg::CFG_W-1:0] nodes_in_use = apsp_pkg::NODE_COUNT_RESET;
	apsp_pkg::res_beat_t        route_replies [$];

	// stimulus planning
	drive_act_t       action_q [$];
	bit               planned [apsp_pkg::MEM_DEPTH];
	int               plan_n       = apsp_pkg::MAX_NODES;
	bit               square_ready = 1'b0;
	pace_t            fill_mode    = PH_SLOW_SINK;
	pace_t            cur_mode     = PH_SLOW_SINK;
	int               stim_items   = 0;

	int quiet_cycles    = 0;
	int cycle_cnt       = 0;
	int fail_cnt        = 0;
	int beats_taken     = 0;
	int replies_checked = 0;
	int runs_checked    = 0;
	int cfg_writes      = 0;

	all_pairs_shortest_path_closure u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_beat  (cmd_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void route_matrix_step(input apsp_pkg::cmd_beat_t b);
		apsp_pkg::res_beat_t          r;
		int                           at;
		int                           n;
		logic [apsp_pkg::DIST_BITS:0] through;
		at = int'(b.row) * apsp_pkg::MAX_NODES + int'(b.col);
		case (b.cmd)
			apsp_pkg::CMD_WRITE: begin
				if (int'(b.row) < apsp_pkg::MAX_NODES && int'(b.col) < apsp_pkg::MAX_NODES)
					route_minutes[at] = b.duration;
			end
			apsp_pkg::CMD_RUN: begin
				n = (int'(nodes_in_use) > apsp_pkg::MAX_NODES) ?
					apsp_pkg::MAX_NODES : int'(nodes_in_use);
				for (int v = 0; v < n; v++)
					for (int f = 0; f < n; f++)
						for (int t = 0; t < n; t++) begin
							through = {1'b0, route_minutes[f*apsp_pkg::MAX_NODES+v]}
								+ route_minutes[v*apsp_pkg::MAX_NODES+t];
							if (through < route_minutes[f*apsp_pkg::MAX_NODES+t])
								route_minutes[f*apsp_pkg::MAX_NODES+t] =
									through[apsp_pkg::DIST_BITS-1:0];
						end
				r.read_value = '0;
				r.done_res   = 1'b1;
				route_replies = {route_replies, r};
			end
			apsp_pkg::CMD_READ: begin
				r.read_value = '0;
				if (int'(b.row) < apsp_pkg::MAX_NODES && int'(b.col) < apsp_pkg::MAX_NODES)
					r.read_value = route_minutes[at];
				r.done_res = 1'b0;
				route_replies = {route_replies, r};
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned pick_minutes();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 5)
			return 0;
		if (roll < 10)
			return 16'hFFFF;
		if (roll < 50)
			return $urandom_range(60, 0);
		if (roll < 75)
			return $urandom_range(1000, 0);
		return $urandom_range(16'hFFFF, 0);
	endfunction

	task automatic push_beat(input logic [1:0] op, input int r, input int c,
			input int unsigned mins);
		drive_act_t a;
		a.kind          = ACT_BEAT;
		a.mode          = fill_mode;
		a.nodes         = '0;
		a.beat.cmd      = op;
		a.beat.row      = r[5:0];
		a.beat.col      = c[5:0];
		a.beat.duration = mins[15:0];
		action_q = {action_q, a};
		if (op == apsp_pkg::CMD_WRITE)
			planned[r*apsp_pkg::MAX_NODES+c] = 1'b1;
		if (op != CMD_UNUSED)
			stim_items++;
	endtask

	task automatic push_cfg(input int n);
		drive_act_t a;
		a.kind  = ACT_CFG;
		a.mode  = fill_mode;
		a.beat  = '0;
		a.nodes = n[apsp_pkg::CFG_W-1:0];
		action_q = {action_q, a};
		plan_n       = (n > apsp_pkg::MAX_NODES) ? apsp_pkg::MAX_NODES : n;
		square_ready = (plan_n == 0);
	endtask

	task automatic push_drain();
		drive_act_t a;
		a.kind  = ACT_DRAIN;
		a.mode  = fill_mode;
		a.beat  = '0;
		a.nodes = '0;
		action_q = {action_q, a};
	endtask

	task automatic fill_square();
		for (int r = 0; r < plan_n; r++)
			for (int c = 0; c < plan_n; c++)
				push_beat(apsp_pkg::CMD_WRITE, r, c, pick_minutes());
		square_ready = 1'b1;
	endtask

	task automatic push_read_written();
		int span;
		int r;
		int c;
		bit found;
		span  = ($urandom_range(1, 0) && plan_n > 0) ? plan_n : apsp_pkg::MAX_NODES;
		found = 1'b0;
		r     = 0;
		c     = 0;
		for (int i = 0; i < 64 && !found; i++) begin
			r     = $urandom_range(span - 1, 0);
			c     = $urandom_range(span - 1, 0);
			found = planned[r*apsp_pkg::MAX_NODES+c];
		end
		if (!found) begin
			r = 0;
			c = 0;
		end
		push_beat(apsp_pkg::CMD_READ, r, c, $urandom_range(16'hFFFF, 0));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : source_proc
		logic                       take;
		logic                       hold;
		drive_act_t                 head;
		apsp_pkg::cmd_beat_t        next_beat;
		logic                       next_we;
		logic [apsp_pkg::CFG_W-1:0] next_wdata;
		int                         idle_pct;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_beat  <= '0;
			cfg_we    <= 1'b0;
			cfg_wdata <= '0;
		end else begin
			take = cmd_valid && !cmd_stall;
			if (take) begin
				route_matrix_step(cmd_beat);
				beats_taken++;
			end
			hold       = cmd_valid && !take;
			next_beat  = cmd_beat;
			next_we    = 1'b0;
			next_wdata = cfg_wdata;
			if (take || cmd_valid || route_replies.size() != 0)
				quiet_cycles = 0;
			else if (quiet_cycles < SETTLE)
				quiet_cycles++;
			if (!hold && action_q.size() != 0) begin
				head     = action_q[0];
				cur_mode = head.mode;
				case (head.kind)
					ACT_BEAT: begin
						idle_pct = (head.mode == PH_SLOW_SINK) ? 31 :
							(head.mode == PH_SLOW_SOURCE) ? 59 : 0;
						if ($urandom_range(99, 0) >= idle_pct) begin
							hold      = 1'b1;
							next_beat = head.beat;
							void'(action_q.pop_front());
						end
					end
					ACT_CFG: begin
						if (quiet_cycles >= SETTLE) begin
							next_we      = 1'b1;
							next_wdata   = head.nodes;
							nodes_in_use = head.nodes;
							quiet_cycles = 0;
							cfg_writes++;
							void'(action_q.pop_front());
						end
					end
					default: begin
						if (quiet_cycles >= SETTLE)
							void'(action_q.pop_front());
					end
				endcase
			end
			cmd_valid <= hold;
			cmd_beat  <= next_beat;
			cfg_we    <= next_we;
			cfg_wdata <= next_wdata;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : sink_proc
		apsp_pkg::res_beat_t want;
		int                  stall_pct;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (route_replies.size() == 0) begin
					$error("unexpected reply beat: read_value %0h done_res %0b",
						res_beat.read_value, res_beat.done_res);
					fail_cnt++;
				end else begin
					want = route_replies.pop_front();
					if (res_beat.read_value !== want.read_value) begin
						$error("read_value mismatch: expected %0h, got %0h",
							want.read_value, res_beat.read_value);
						fail_cnt++;
					end
					if (res_beat.done_res !== want.done_res) begin
						$error("done_res mismatch: expected %0b, got %0b",
							want.done_res, res_beat.done_res);
						fail_cnt++;
					end
					replies_checked++;
					if (want.done_res)
						runs_checked++;
				end
			end
			stall_pct = (cur_mode == PH_SLOW_SINK) ? 59 :
				(cur_mode == PH_SLOW_SOURCE) ? 31 : 0;
			res_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus_proc
		int base;
		int n;
		int pick;

		// directed: field extremes, unused command, node counts 0, 1, 2
		fill_mode = PH_SLOW_SINK;
		push_cfg(apsp_pkg::MAX_NODES);
		push_beat(apsp_pkg::CMD_WRITE, 0, 0, 16'h0000);
		push_beat(apsp_pkg::CMD_WRITE, 63, 63, 16'hFFFF);
		push_beat(apsp_pkg::CMD_WRITE, 0, 63, 16'hAAAA);
		push_beat(apsp_pkg::CMD_WRITE, 63, 0, 16'h5555);
		push_beat(apsp_pkg::CMD_READ, 63, 63, 16'hFFFF);
		push_beat(apsp_pkg::CMD_READ, 0, 63, 16'h0000);
		push_beat(apsp_pkg::CMD_READ, 63, 0, 16'h0000);
		push_beat(apsp_pkg::CMD_READ, 0, 0, 16'hFFFF);
		push_beat(CMD_UNUSED, 0, 0, 16'h1234);
		push_beat(apsp_pkg::CMD_READ, 0, 0, 16'h0000);
		push_cfg(0);
		push_beat(apsp_pkg::CMD_RUN, 63, 63, 16'hFFFF);
		push_beat(apsp_pkg::CMD_READ, 0, 63, 16'h0000);
		push_cfg(1);
		push_beat(apsp_pkg::CMD_WRITE, 0, 0, 16'h0007);
		push_beat(apsp_pkg::CMD_RUN, 0, 0, 16'h0000);
		push_beat(apsp_pkg::CMD_READ, 0, 0, 16'h0000);
		// sums above 16 bits must not look shorter
		push_cfg(2);
		push_beat(apsp_pkg::CMD_WRITE, 0, 0, 16'hFFFF);
		push_beat(apsp_pkg::CMD_WRITE, 0, 1, 16'hFFFF);
		push_beat(apsp_pkg::CMD_WRITE, 1, 0, 16'hFFFF);
		push_beat(apsp_pkg::CMD_WRITE, 1, 1, 16'hFFFE);
		square_ready = 1'b1;
		push_beat(apsp_pkg::CMD_RUN, 0, 0, 16'h0000);
		push_beat(apsp_pkg::CMD_READ, 0, 0, 16'h0000);
		push_beat(apsp_pkg::CMD_READ, 1, 1, 16'h0000);

		base = stim_items;
		while (stim_items - base < RANDOM_ITEMS) begin
			if (stim_items - base < RANDOM_ITEMS / 3)
				fill_mode = PH_SLOW_SINK;
			else if (stim_items - base < 2 * RANDOM_ITEMS / 3)
				fill_mode = PH_SLOW_SOURCE;
			else
				fill_mode = PH_FREE;
			if ($urandom_range(99, 0) < 65) begin
				pick = $urandom_range(99, 0);
				n = (pick < 80) ? $urandom_range(6, 1) :
					(pick < 95) ? $urandom_range(10, 7) : 0;
				if ($urandom_range(3, 0) == 0)
					push_drain();
				push_cfg(n);
				fill_square();
				push_beat(apsp_pkg::CMD_RUN, $urandom_range(63, 0), $urandom_range(63, 0),
					$urandom_range(16'hFFFF, 0));
				repeat ($urandom_range(6, 1))
					push_read_written();
			end else begin
				repeat ($urandom_range(20, 5)) begin
					pick = $urandom_range(99, 0);
					if (pick < 40)
						push_beat(apsp_pkg::CMD_WRITE, $urandom_range(63, 0),
							$urandom_range(63, 0), pick_minutes());
					else if (pick < 80)
						push_read_written();
					else if (pick < 88)
						push_beat(CMD_UNUSED, $urandom_range(63, 0),
							$urandom_range(63, 0), $urandom_range(16'hFFFF, 0));
					else if (pick < 95 && square_ready)
						push_beat(apsp_pkg::CMD_RUN, $urandom_range(63, 0),
							$urandom_range(63, 0), $urandom_range(16'hFFFF, 0));
					else
						push_drain();
				end
			end
		end

		// oversized node count, then reads of written entries
		fill_mode = PH_FREE;
		push_drain();
		push_cfg(127);
		repeat (30)
			push_read_written();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (action_q.size() != 0 || cmd_valid || route_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d command beats taken, %0d replies checked, %0d closure runs",
			beats_taken, replies_checked, runs_checked);
		$display("tb: %0d node-count writes, from zero up to an oversized count",
			cfg_writes);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
